FILE: rtl/core/min_priority_queue_linear_scan_defines.svh
// Assertion macros for the priority queue RTL.
`ifndef MIN_PRIORITY_QUEUE_LINEAR_SCAN_DEFINES_SVH
`define MIN_PRIORITY_QUEUE_LINEAR_SCAN_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk and idle during rst.
`define MPQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, sampled on clk and idle during rst.
`define MPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MPQ_ASSERT_NOW(lbl, ante, cons)
`define MPQ_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/core/mpq_pkg.sv
// Types and codes for the linear-scan priority queue.
package mpq_pkg;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } state_t;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

endpackage

FILE: rtl/core/min_priority_queue_linear_scan.sv
// Bounded min-priority queue kept unsorted in one RAM and served by a linear scan.
//
// The queue holds up to CAPACITY (value, priority) pairs in a single simple
// dual-port RAM of 64-bit entries with a registered read, one write and one
// read per cycle. An insert beat appends its pair at the end of the store and
// then goes to the done state. A remove beat streams every held entry out of
// the RAM, one per cycle, keeping the entry with the smallest signed priority
// (larger signed value on a tie, earliest entry on a full tie), then closes
// the gap by reading each later entry and writing it one place lower, again
// one entry per cycle. Overflow and underflow beats leave the store untouched.
// The result sits in an output register, and the block keeps the slave side
// closed while an operation is in progress or its result cannot yet be handed
// over. The RAM needs no clearing after reset since only entries below the
// fill count are ever read.
`include "min_priority_queue_linear_scan_defines.svh"

module min_priority_queue_linear_scan #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Input beats.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // item_value [31:0], item_priority [63:32]
  input  logic [0:0]  s_axis_tuser,   // operation [0]: 0 insert, 1 remove
  // Result beats.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // removed_value [31:0], occupancy [36:32], zero pad
  output logic [1:0]  m_axis_tuser    // status [1:0]
);
  import mpq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  // RAM holding {priority, value} per entry.
  logic [63:0]   mem [CAPACITY];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [63:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [63:0]   rdata;

  state_t        state, state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] idx;        // next address to read, in scan and in compaction
  logic          rd_pend;    // rdata holds the entry at rd_idx this cycle
  logic [AW-1:0] rd_idx;
  logic [AW-1:0] best_idx;
  logic signed [31:0] best_pri;
  logic signed [31:0] best_val;
  logic signed [31:0] cand_pri;
  logic signed [31:0] cand_val;
  logic          cand_better;
  logic          take;
  logic          s_fire;
  logic          ins_beat;
  logic          out_free;
  logic          not_full;
  logic [AW-1:0] last_idx;
  logic [AW-1:0] win_idx;

  status_t       res_status;
  logic [31:0]   res_val;
  status_t       out_status;
  logic [31:0]   out_val;
  logic [4:0]    out_occ;

  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign ins_beat = s_fire && (s_axis_tuser[0] == OP_INSERT);
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign not_full = count < CW'(CAPACITY);
  assign cnt_m1   = count - CW'(1);
  assign last_idx = cnt_m1[AW-1:0];

  assign cand_pri = $signed(rdata[63:32]);
  assign cand_val = $signed(rdata[31:0]);
  assign cand_better = (cand_pri < best_pri) ||
                       ((cand_pri == best_pri) && (cand_val > best_val));
  // The first entry seeds the scan; later entries replace it only when better.
  assign take    = rd_pend && ((rd_idx == '0) || cand_better);
  assign win_idx = take ? rd_idx : best_idx;

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tdata  = {3'b000, out_occ, out_val};
  assign m_axis_tuser  = out_status;

  // RAM: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and RAM controls.
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = count[AW-1:0];
    mem_wdata  = s_axis_tdata;
    mem_re     = 1'b0;
    mem_raddr  = idx[AW-1:0];
    case (state)
      ST_IDLE: begin
        if (s_fire) begin
          if (s_axis_tuser[0] == OP_INSERT) begin
            mem_we     = not_full;
            state_next = ST_DONE;
          end else if (count == '0) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        mem_re = (idx < count);
        if (rd_pend && (rd_idx == last_idx)) begin
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        mem_re = (idx < count);
        // Each entry read last cycle moves down by one place.
        if (rd_pend) begin
          mem_we    = 1'b1;
          mem_waddr = rd_idx - AW'(1);
          mem_wdata = rdata;
        end
        // The last write, if any, lands on the same edge that leaves compaction.
        if (!(idx < count)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control datapath: fill count and read tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= mem_re;
      if (state == ST_IDLE && ins_beat && not_full) begin
        count <= count + CW'(1);
      end else if (state == ST_SHIFT && state_next == ST_DONE) begin
        count <= cnt_m1;
      end
    end
  end

  // Payload datapath: scan pointer, running winner and pending result.
  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_idx <= idx[AW-1:0];
      idx    <= idx + CW'(1);
    end
    if (state == ST_SCAN && take) begin
      best_idx <= rd_idx;
      best_pri <= cand_pri;
      best_val <= cand_val;
    end
    case (state)
      ST_IDLE: begin
        idx <= '0;
        if (s_fire) begin
          res_val <= '0;
          if (s_axis_tuser[0] == OP_INSERT) begin
            res_status <= not_full ? STATUS_OK : STATUS_OVERFLOW;
          end else begin
            res_status <= (count == '0) ? STATUS_UNDERFLOW : STATUS_OK;
          end
        end
      end
      ST_SCAN: begin
        // Compaction starts reading just past the winner.
        if (state_next == ST_SHIFT) begin
          idx <= CW'(win_idx) + CW'(1);
        end
      end
      ST_SHIFT: begin
        if (state_next == ST_DONE) begin
          res_val <= best_val;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_status <= res_status;
      out_val    <= res_val;
      out_occ    <= 5'(count);
    end
  end

  // The fill count never passes the capacity.
  `MPQ_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(CAPACITY))
  // No RAM read is outstanding once the block is back at rest.
  `MPQ_ASSERT_NOW(a_idle_quiet, state == ST_IDLE, !rd_pend)
  // Compaction always starts from a held entry.
  `MPQ_ASSERT_NOW(a_best_held, state == ST_SHIFT, CW'(best_idx) < count)
  // An accepted insert with room grows the store by exactly one entry.
  `MPQ_ASSERT_NEXT(a_insert_grows, ins_beat && not_full, count == $past(count) + CW'(1))
  // An insert into a full store leaves the fill count alone.
  `MPQ_ASSERT_NEXT(a_overflow_keeps, ins_beat && !not_full, count == $past(count))

endmodule
